@@ sv/edc_pkg.sv @@
// ----------------------------------------------------------------------------
// edc_pkg: shared types and constants for the elastic disk collision block
// Field widths, internal datapath widths, register indexes and the bundles
// that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int POS_W     = 19;
  localparam int VEL_W     = 16;
  localparam int CFG_W     = 8;
  localparam int IDX_W     = 2;

  localparam int D_W       = POS_W + 1;        // signed center offset
  localparam int DV_W      = VEL_W + 1;        // signed velocity difference
  localparam int D2_W      = 2 * D_W;          // squared distance
  localparam int DOT_W     = DV_W + D_W;       // signed dot product
  localparam int DMAG_W    = DOT_W - 1;        // dot product magnitude
  localparam int DABS_W    = POS_W;            // offset magnitude
  localparam int HALF_W    = DMAG_W / 2;       // split of the dot magnitude
  localparam int PROD_W    = HALF_W + DABS_W;  // one partial product
  localparam int MAGP_W    = DMAG_W + DABS_W;  // |dot * d|
  localparam int M_W       = CFG_W + 1;        // mass sum and doubled mass
  localparam int NUM_W     = 64;               // dividend
  localparam int DEN_W     = M_W + D2_W;       // divisor
  localparam int QW        = 18;               // quotient bits
  localparam int QR_W      = QW + 1;           // rounded quotient
  localparam int LANES     = 4;

  localparam int GEOM_STAGES = 6;
  localparam int DIV_STAGES  = QW + 1;
  localparam int UPD_STAGES  = 2;
  localparam int LATENCY     = GEOM_STAGES + DIV_STAGES + UPD_STAGES;

  localparam logic [IDX_W-1:0] REG_RADIUS_A = 2'd0;
  localparam logic [IDX_W-1:0] REG_RADIUS_B = 2'd1;
  localparam logic [IDX_W-1:0] REG_MASS_A   = 2'd2;
  localparam logic [IDX_W-1:0] REG_MASS_B   = 2'd3;

  localparam logic [CFG_W-1:0] RADIUS_A_RST = 8'd45;
  localparam logic [CFG_W-1:0] RADIUS_B_RST = 8'd58;
  localparam logic [CFG_W-1:0] MASS_A_RST   = 8'd9;
  localparam logic [CFG_W-1:0] MASS_B_RST   = 8'd70;

  // Lane order of the dividers.
  localparam int LANE_AX = 0;
  localparam int LANE_AY = 1;
  localparam int LANE_BX = 2;
  localparam int LANE_BY = 3;

  typedef struct packed {
    logic [POS_W-1:0] a_pos_x;
    logic [POS_W-1:0] a_pos_y;
    logic [VEL_W-1:0] a_vel_x;
    logic [VEL_W-1:0] a_vel_y;
    logic [POS_W-1:0] b_pos_x;
    logic [POS_W-1:0] b_pos_y;
    logic [VEL_W-1:0] b_vel_x;
    logic [VEL_W-1:0] b_vel_y;
    logic             hit;
    logic             neg_x;
    logic             neg_y;
  } carry_t;

  typedef struct packed {
    logic [M_W-1:0]  mass_sum;
    logic [M_W-1:0]  two_ma;
    logic [M_W-1:0]  two_mb;
    logic [D2_W-1:0] lim;
  } geom_cfg_t;

endpackage

@@ sv/edc_geom.sv @@
// ----------------------------------------------------------------------------
// edc_geom: contact test and dividend/divisor setup
// Six register stages: offsets, products, contact test, split products and
// divisor, product recombine, mass scaling of the four dividends.
// ----------------------------------------------------------------------------
module edc_geom import edc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [POS_W-1:0]             a_pos_x,
  input  logic [POS_W-1:0]             a_pos_y,
  input  logic signed [VEL_W-1:0]      a_vel_x,
  input  logic signed [VEL_W-1:0]      a_vel_y,
  input  logic [POS_W-1:0]             b_pos_x,
  input  logic [POS_W-1:0]             b_pos_y,
  input  logic signed [VEL_W-1:0]      b_vel_x,
  input  logic signed [VEL_W-1:0]      b_vel_y,
  input  geom_cfg_t                    cfg,
  output logic                         valid,
  output carry_t                       carry,
  output logic [DEN_W-1:0]             den,
  output logic [LANES-1:0][NUM_W-1:0]  num
);

  // Stage 1
  logic                    s1_valid;
  carry_t                  s1_carry;
  logic signed [D_W-1:0]   s1_dx, s1_dy;
  logic signed [DV_W-1:0]  s1_dvx, s1_dvy;
  // Stage 2
  logic                    s2_valid;
  carry_t                  s2_carry;
  logic signed [D_W-1:0]   s2_dx, s2_dy;
  logic signed [D2_W-1:0]  s2_dxx, s2_dyy;
  logic signed [DOT_W-1:0] s2_dotx, s2_doty;
  // Stage 3
  logic                    s3_valid;
  carry_t                  s3_carry;
  carry_t                  s3_carry_next;
  logic signed [D_W-1:0]   s3_dx, s3_dy;
  logic [D2_W-1:0]         s3_d2;
  logic signed [DOT_W-1:0] s3_dot;
  logic [D2_W-1:0]         d2_sum;
  // Stage 4
  logic                    s4_valid;
  carry_t                  s4_carry;
  carry_t                  s4_carry_next;
  logic [PROD_W-1:0]       s4_px_lo, s4_px_hi, s4_py_lo, s4_py_hi;
  logic [DEN_W-1:0]        s4_den;
  logic                    dot_neg, dx_neg, dy_neg;
  logic signed [DOT_W-1:0] dot_neg_val;
  logic signed [D_W-1:0]   dx_neg_val, dy_neg_val;
  logic [DMAG_W-1:0]       dot_mag;
  logic [DABS_W-1:0]       dx_abs, dy_abs;
  // Stage 5
  logic                    s5_valid;
  carry_t                  s5_carry;
  logic [MAGP_W-1:0]       s5_magx, s5_magy;
  logic [DEN_W-1:0]        s5_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      valid    <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_carry.a_pos_x <= a_pos_x;
    s1_carry.a_pos_y <= a_pos_y;
    s1_carry.a_vel_x <= a_vel_x;
    s1_carry.a_vel_y <= a_vel_y;
    s1_carry.b_pos_x <= b_pos_x;
    s1_carry.b_pos_y <= b_pos_y;
    s1_carry.b_vel_x <= b_vel_x;
    s1_carry.b_vel_y <= b_vel_y;
    s1_carry.hit     <= 1'b0;
    s1_carry.neg_x   <= 1'b0;
    s1_carry.neg_y   <= 1'b0;
    s1_dx  <= $signed({1'b0, b_pos_x}) - $signed({1'b0, a_pos_x});
    s1_dy  <= $signed({1'b0, b_pos_y}) - $signed({1'b0, a_pos_y});
    s1_dvx <= $signed({b_vel_x[VEL_W-1], b_vel_x}) - $signed({a_vel_x[VEL_W-1], a_vel_x});
    s1_dvy <= $signed({b_vel_y[VEL_W-1], b_vel_y}) - $signed({a_vel_y[VEL_W-1], a_vel_y});
  end

  always_ff @(posedge clk) begin
    s2_carry <= s1_carry;
    s2_dx    <= s1_dx;
    s2_dy    <= s1_dy;
    s2_dxx   <= s1_dx * s1_dx;
    s2_dyy   <= s1_dy * s1_dy;
    s2_dotx  <= s1_dvx * s1_dx;
    s2_doty  <= s1_dvy * s1_dy;
  end

  // Both squares are non-negative and below 2^38, so the sum fits unsigned.
  assign d2_sum = $unsigned(s2_dxx) + $unsigned(s2_dyy);

  always_comb begin
    s3_carry_next     = s2_carry;
    s3_carry_next.hit = (d2_sum != '0) && (d2_sum <= cfg.lim);
  end

  always_ff @(posedge clk) begin
    s3_carry <= s3_carry_next;
    s3_dx    <= s2_dx;
    s3_dy    <= s2_dy;
    s3_d2    <= d2_sum;
    s3_dot   <= s2_dotx + s2_doty;
  end

  always_comb begin
    dot_neg     = s3_dot[DOT_W-1];
    dx_neg      = s3_dx[D_W-1];
    dy_neg      = s3_dy[D_W-1];
    dot_neg_val = -s3_dot;
    dx_neg_val  = -s3_dx;
    dy_neg_val  = -s3_dy;
    dot_mag     = dot_neg ? dot_neg_val[DMAG_W-1:0] : s3_dot[DMAG_W-1:0];
    dx_abs      = dx_neg ? dx_neg_val[DABS_W-1:0] : s3_dx[DABS_W-1:0];
    dy_abs      = dy_neg ? dy_neg_val[DABS_W-1:0] : s3_dy[DABS_W-1:0];
    s4_carry_next       = s3_carry;
    s4_carry_next.neg_x = dot_neg ^ dx_neg;
    s4_carry_next.neg_y = dot_neg ^ dy_neg;
  end

  always_ff @(posedge clk) begin
    s4_carry <= s4_carry_next;
    s4_px_lo <= dot_mag[HALF_W-1:0] * dx_abs;
    s4_px_hi <= dot_mag[DMAG_W-1:HALF_W] * dx_abs;
    s4_py_lo <= dot_mag[HALF_W-1:0] * dy_abs;
    s4_py_hi <= dot_mag[DMAG_W-1:HALF_W] * dy_abs;
    s4_den   <= cfg.mass_sum * s3_d2;
  end

  always_ff @(posedge clk) begin
    s5_carry <= s4_carry;
    s5_magx  <= {s4_px_hi, {HALF_W{1'b0}}} + MAGP_W'(s4_px_lo);
    s5_magy  <= {s4_py_hi, {HALF_W{1'b0}}} + MAGP_W'(s4_py_lo);
    s5_den   <= s4_den;
  end

  always_ff @(posedge clk) begin
    carry        <= s5_carry;
    den          <= s5_den;
    num[LANE_AX] <= cfg.two_mb * s5_magx;
    num[LANE_AY] <= cfg.two_mb * s5_magy;
    num[LANE_BX] <= cfg.two_ma * s5_magx;
    num[LANE_BY] <= cfg.two_ma * s5_magy;
  end

endmodule

@@ sv/edc_div.sv @@
// ----------------------------------------------------------------------------
// edc_div: pipelined restoring divider, four lanes sharing one divisor
// One quotient bit per stage, then a rounding stage that rounds half away
// from zero on the magnitude.
// ----------------------------------------------------------------------------
module edc_div import edc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  carry_t                       in_carry,
  input  logic [DEN_W-1:0]             in_den,
  input  logic [LANES-1:0][NUM_W-1:0]  in_num,
  output logic                         out_valid,
  output carry_t                       out_carry,
  output logic [LANES-1:0][QR_W-1:0]   out_quot
);

  localparam int TRY_W = DEN_W + QW;

  logic                         vld [QW+1];
  carry_t                       car [QW+1];
  logic [DEN_W-1:0]             dvs [QW+1];
  logic [LANES-1:0][NUM_W-1:0]  rem [QW+1];
  logic [LANES-1:0][QW-1:0]     quo [QW+1];

  assign vld[0] = in_valid;
  assign car[0] = in_carry;
  assign dvs[0] = in_den;
  assign rem[0] = in_num;
  assign quo[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [TRY_W-1:0] sh;
    logic [LANES-1:0][NUM_W-1:0] rem_next;
    logic [LANES-1:0][QW-1:0]    quo_next;

    assign sh = TRY_W'(dvs[j]) << B;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [TRY_W-1:0] diff;
      logic             ge;
      always_comb begin
        ge          = TRY_W'(rem[j][l]) >= sh;
        diff        = TRY_W'(rem[j][l]) - sh;
        rem_next[l] = ge ? diff[NUM_W-1:0] : rem[j][l];
        quo_next[l] = quo[j][l];
        quo_next[l][B] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      car[j+1] <= car[j];
      dvs[j+1] <= dvs[j];
      rem[j+1] <= rem_next;
      quo[j+1] <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_carry <= car[QW];
    for (int l = 0; l < LANES; l++) begin
      out_quot[l] <= QR_W'(quo[QW][l]) +
                     QR_W'({rem[QW][l], 1'b0} >= (NUM_W+1)'(dvs[QW]));
    end
  end

endmodule

@@ sv/edc_update.sv @@
// ----------------------------------------------------------------------------
// edc_update: velocity and position update with saturation
// Applies the signed velocity changes, saturates velocities, then moves the
// disks and saturates positions. Items without contact pass through.
// ----------------------------------------------------------------------------
module edc_update import edc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  carry_t                      in_carry,
  input  logic [LANES-1:0][QR_W-1:0]  in_quot,
  output logic                        done,
  output logic [POS_W-1:0]            new_a_pos_x,
  output logic [POS_W-1:0]            new_a_pos_y,
  output logic signed [VEL_W-1:0]     new_a_vel_x,
  output logic signed [VEL_W-1:0]     new_a_vel_y,
  output logic [POS_W-1:0]            new_b_pos_x,
  output logic [POS_W-1:0]            new_b_pos_y,
  output logic signed [VEL_W-1:0]     new_b_vel_x,
  output logic signed [VEL_W-1:0]     new_b_vel_y,
  output logic                        contact
);

  localparam int SUM_W = QR_W + 2;

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
    logic [VEL_W-1:0] r;
    if (v > SUM_W'($signed({1'b0, {(VEL_W-1){1'b1}}}))) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else if (v < -SUM_W'($signed({1'b0, {(VEL_W-1){1'b1}}})) - 1) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > SUM_W'($signed({1'b0, {POS_W{1'b1}}}))) begin
      r = '1;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_vel(input logic [VEL_W-1:0] v);
    return SUM_W'($signed(v));
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_pos(input logic [POS_W-1:0] p);
    return $signed(SUM_W'(p));
  endfunction

  logic                     u1_valid;
  carry_t                   u1_carry;
  logic [VEL_W-1:0]         u1_avx, u1_avy, u1_bvx, u1_bvy;
  logic signed [SUM_W-1:0]  dax, day, dbx, dby;

  always_comb begin
    dax = in_carry.neg_x ? -ext_pos(in_quot[LANE_AX]) : ext_pos(in_quot[LANE_AX]);
    day = in_carry.neg_y ? -ext_pos(in_quot[LANE_AY]) : ext_pos(in_quot[LANE_AY]);
    dbx = in_carry.neg_x ? -ext_pos(in_quot[LANE_BX]) : ext_pos(in_quot[LANE_BX]);
    dby = in_carry.neg_y ? -ext_pos(in_quot[LANE_BY]) : ext_pos(in_quot[LANE_BY]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      u1_valid <= in_valid;
      done     <= u1_valid;
    end
  end

  always_ff @(posedge clk) begin
    u1_carry <= in_carry;
    u1_avx   <= sat_vel(ext_vel(in_carry.a_vel_x) + dax);
    u1_avy   <= sat_vel(ext_vel(in_carry.a_vel_y) + day);
    u1_bvx   <= sat_vel(ext_vel(in_carry.b_vel_x) - dbx);
    u1_bvy   <= sat_vel(ext_vel(in_carry.b_vel_y) - dby);
  end

  always_ff @(posedge clk) begin
    contact <= u1_carry.hit;
    if (u1_carry.hit) begin
      new_a_vel_x <= u1_avx;
      new_a_vel_y <= u1_avy;
      new_b_vel_x <= u1_bvx;
      new_b_vel_y <= u1_bvy;
      new_a_pos_x <= sat_pos(ext_pos(u1_carry.a_pos_x) + ext_vel(u1_avx));
      new_a_pos_y <= sat_pos(ext_pos(u1_carry.a_pos_y) + ext_vel(u1_avy));
      new_b_pos_x <= sat_pos(ext_pos(u1_carry.b_pos_x) + ext_vel(u1_bvx));
      new_b_pos_y <= sat_pos(ext_pos(u1_carry.b_pos_y) + ext_vel(u1_bvy));
    end else begin
      new_a_vel_x <= u1_carry.a_vel_x;
      new_a_vel_y <= u1_carry.a_vel_y;
      new_b_vel_x <= u1_carry.b_vel_x;
      new_b_vel_y <= u1_carry.b_vel_y;
      new_a_pos_x <= u1_carry.a_pos_x;
      new_a_pos_y <= u1_carry.a_pos_y;
      new_b_pos_x <= u1_carry.b_pos_x;
      new_b_pos_y <= u1_carry.b_pos_y;
    end
  end

endmodule

@@ sv/elastic_disk_collision.sv @@
// ----------------------------------------------------------------------------
// elastic_disk_collision: two-disk elastic collision response
// A request passes through the geometry section, the divider and the update
// section, and its result shows with done high. Throughput: one request per
// cycle; busy is always low and the receiver cannot stall.
// Reset: synchronous; clears the pipeline valid bits and loads the register
// defaults (radii 45 and 58, masses 9 and 70).
// ----------------------------------------------------------------------------
module elastic_disk_collision import edc_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [POS_W-1:0]         a_pos_x,
  input  logic [POS_W-1:0]         a_pos_y,
  input  logic signed [VEL_W-1:0]  a_vel_x,
  input  logic signed [VEL_W-1:0]  a_vel_y,
  input  logic [POS_W-1:0]         b_pos_x,
  input  logic [POS_W-1:0]         b_pos_y,
  input  logic signed [VEL_W-1:0]  b_vel_x,
  input  logic signed [VEL_W-1:0]  b_vel_y,
  output logic [POS_W-1:0]         new_a_pos_x,
  output logic [POS_W-1:0]         new_a_pos_y,
  output logic signed [VEL_W-1:0]  new_a_vel_x,
  output logic signed [VEL_W-1:0]  new_a_vel_y,
  output logic [POS_W-1:0]         new_b_pos_x,
  output logic [POS_W-1:0]         new_b_pos_y,
  output logic signed [VEL_W-1:0]  new_b_vel_x,
  output logic signed [VEL_W-1:0]  new_b_vel_y,
  output logic                     contact
);

  localparam int LIM_W = 2 * M_W + 2 * FRAC_BITS;
  localparam int CMP_W = (LIM_W > D2_W) ? LIM_W : D2_W;

  logic [CFG_W-1:0]      radius_a, radius_b, mass_a, mass_b;
  logic [CFG_W-1:0]      ma1, mb1;
  logic [M_W-1:0]        rsum;
  logic [2*M_W-1:0]      rsq;
  logic [CMP_W-1:0]      lim_wide;
  geom_cfg_t             gcfg;

  logic                         g_valid, d_valid;
  carry_t                       g_carry, d_carry;
  logic [DEN_W-1:0]             g_den;
  logic [LANES-1:0][NUM_W-1:0]  g_num;
  logic [LANES-1:0][QR_W-1:0]   d_quot;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_a <= RADIUS_A_RST;
      radius_b <= RADIUS_B_RST;
      mass_a   <= MASS_A_RST;
      mass_b   <= MASS_B_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS_A: radius_a <= cfg_data;
        REG_RADIUS_B: radius_b <= cfg_data;
        REG_MASS_A:   mass_a   <= cfg_data;
        REG_MASS_B:   mass_b   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero mass acts as mass one. The contact limit is clipped to the
  // squared-distance width, which no squared distance can reach.
  always_comb begin
    ma1           = (mass_a == '0) ? CFG_W'(1) : mass_a;
    mb1           = (mass_b == '0) ? CFG_W'(1) : mass_b;
    rsum          = M_W'(radius_a) + M_W'(radius_b);
    rsq           = rsum * rsum;
    lim_wide      = CMP_W'(rsq) << (2 * FRAC_BITS);
    gcfg.mass_sum = M_W'(ma1) + M_W'(mb1);
    gcfg.two_ma   = {ma1, 1'b0};
    gcfg.two_mb   = {mb1, 1'b0};
    gcfg.lim      = (lim_wide > CMP_W'({D2_W{1'b1}})) ? '1 : lim_wide[D2_W-1:0];
  end

  edc_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .a_pos_x (a_pos_x),
    .a_pos_y (a_pos_y),
    .a_vel_x (a_vel_x),
    .a_vel_y (a_vel_y),
    .b_pos_x (b_pos_x),
    .b_pos_y (b_pos_y),
    .b_vel_x (b_vel_x),
    .b_vel_y (b_vel_y),
    .cfg     (gcfg),
    .valid   (g_valid),
    .carry   (g_carry),
    .den     (g_den),
    .num     (g_num)
  );

  edc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_carry  (g_carry),
    .in_den    (g_den),
    .in_num    (g_num),
    .out_valid (d_valid),
    .out_carry (d_carry),
    .out_quot  (d_quot)
  );

  edc_update u_update (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d_valid),
    .in_carry    (d_carry),
    .in_quot     (d_quot),
    .done        (done),
    .new_a_pos_x (new_a_pos_x),
    .new_a_pos_y (new_a_pos_y),
    .new_a_vel_x (new_a_vel_x),
    .new_a_vel_y (new_a_vel_y),
    .new_b_pos_x (new_b_pos_x),
    .new_b_pos_y (new_b_pos_y),
    .new_b_vel_x (new_b_vel_x),
    .new_b_vel_y (new_b_vel_y),
    .contact     (contact)
  );

  // Every result traces back to a matching request.
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !rst, LATENCY))
    else $error("result without a matching request");

  // Without contact, disk A's position passes through untouched.
  a_pass_pos: assert property (@(posedge clk) disable iff (rst)
    (done && !contact) |-> (new_a_pos_x == $past(a_pos_x, LATENCY) &&
                            new_a_pos_y == $past(a_pos_y, LATENCY)))
    else $error("position changed without contact");

  // Without contact, disk B's velocity passes through untouched.
  a_pass_vel: assert property (@(posedge clk) disable iff (rst)
    (done && !contact) |-> (new_b_vel_x == $past(b_vel_x, LATENCY) &&
                            new_b_vel_y == $past(b_vel_y, LATENCY)))
    else $error("velocity changed without contact");

endmodule
